// ===== hw/rtl/es2cd_pkg.sv =====
// ----------------------------------------------------------------------------
// es2cd_pkg
// Field types and constants for the seconds-to-calendar-date pipeline.
// ----------------------------------------------------------------------------
package es2cd_pkg;

    typedef logic [31:0] epoch_t;
    typedef logic [11:0] year_t;
    typedef logic [3:0]  month_t;
    typedef logic [4:0]  day_t;
    typedef logic [4:0]  hour_t;
    typedef logic [5:0]  minute_t;
    typedef logic [5:0]  second_t;

    localparam int unsigned NUM_STAGES = 9;

    // seconds per day is 675 * 2^7: shift off seven bits, then divide by 675
    localparam int unsigned SOD_SHIFT       = 7;
    localparam logic [25:0] RECIP_675       = 26'd50903316;
    localparam int unsigned RECIP_675_SHIFT = 35;
    localparam logic [9:0]  DIV_675         = 10'd675;

    // divide by 60 as a shift by two and a multiply by the reciprocal of 15
    localparam logic [15:0] RECIP_15        = 16'd34953;
    localparam int unsigned RECIP_15_SHIFT  = 19;

    localparam logic [17:0] DAYS_400Y       = 18'd146097;
    localparam logic [15:0] DAYS_100Y       = 16'd36524;
    localparam logic [10:0] DAYS_4Y         = 11'd1461;
    localparam logic [8:0]  DAYS_1Y         = 9'd365;
    localparam logic [17:0] JAN_FEB_DAYS    = 18'd60;
    localparam logic [17:0] DAYS_REBASE     = DAYS_400Y - JAN_FEB_DAYS;

    localparam logic [15:0] RECIP_1461       = 16'd45934;
    localparam int unsigned RECIP_1461_SHIFT = 26;
    localparam logic [4:0]  C4_CLAMP         = 5'd25;

    localparam year_t BASE_YEAR   = 12'd1600;
    localparam year_t YEARS_400   = 12'd400;

    localparam logic [17:0] CENT_DAYS  [4] = '{18'd0, 18'd36524, 18'd73048, 18'd109572};
    localparam year_t       CENT_YEARS [4] = '{12'd0, 12'd100, 12'd200, 12'd300};
    localparam logic [10:0] YEAR_DAYS  [4] = '{11'd0, 11'd365, 11'd730, 11'd1095};

    // first day of each month, counted from march 1st
    localparam logic [8:0] MONTH_START [12] = '{
        9'd0,   9'd31,  9'd61,  9'd92,  9'd122, 9'd153,
        9'd184, 9'd214, 9'd245, 9'd275, 9'd306, 9'd337
    };
    localparam logic [3:0] FIRST_NEXT_YEAR_MONTH = 4'd10;

endpackage

// ===== hw/rtl/epoch_seconds_to_calendar_date_unit.sv =====
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_date_unit
// Converts an unsigned count of seconds since 2000-01-01 00:00:00 UTC into
// the Gregorian year, month, day, hour, minute and second (no leap seconds).
// Every 32-bit count is valid; the last one falls in February 2136. The unit
// is a nine-stage pipeline, stages 0 to 8, and a new request is taken in
// every cycle unless the result port stalls and every stage is full. Each
// stage holds its own valid bit, so a stalled result port only holds the
// stages that are full, and empty stages keep filling behind it. The depth
// is set by the chain of reciprocal multiplies and compares that split the
// count into days, 400-, 100-, 4- and 1-year cycles, and months.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_date_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  es2cd_pkg::epoch_t   s_epoch_seconds,
    output logic                m_valid,
    input  logic                m_ready,
    output es2cd_pkg::year_t    m_year,
    output es2cd_pkg::month_t   m_month,
    output es2cd_pkg::day_t     m_day,
    output es2cd_pkg::hour_t    m_hour,
    output es2cd_pkg::minute_t  m_minute,
    output es2cd_pkg::second_t  m_second
);
    import es2cd_pkg::*;

    logic [NUM_STAGES-1:0] vld_reg, vld_next;
    logic [NUM_STAGES-1:0] stage_en;

    // stage 0: day quotient estimate
    logic [50:0] s0_prod;
    logic [15:0] q0_reg;
    logic [24:0] x0_reg;
    logic [6:0]  lo0_reg;
    // stage 1: estimate times divisor
    logic [25:0] s1_prod;
    logic [15:0] q1_reg;
    logic [24:0] x1_reg;
    logic [24:0] qm1_reg;
    logic [6:0]  lo1_reg;
    // stage 2: correction, days and second of day
    logic [24:0] s2_diff;
    logic [10:0] s2_rem;
    logic [15:0] wd2_reg;
    logic [16:0] sod2_reg;
    // stage 3: 400-year cycle, minutes of day
    logic [17:0] s3_days;
    logic [30:0] s3_prod;
    logic        s3_c400;
    logic [17:0] rem0_3_reg;
    logic        c400_3_reg;
    logic [16:0] sod3_reg;
    logic [10:0] mins3_reg;
    // stage 4: 100-year cycle, second and hour
    logic [1:0]  s4_c100;
    logic [17:0] s4_rem;
    logic [16:0] s4_sec;
    logic [24:0] s4_prod;
    logic [15:0] rem1_4_reg;
    year_t       year4_reg;
    logic [10:0] mins4_reg;
    hour_t       hour4_reg;
    second_t     sec4_reg;
    // stage 5: 4-year cycle estimate, minute
    logic [31:0] s5_prod;
    logic [10:0] s5_min;
    logic [4:0]  c4raw5_reg;
    logic [15:0] rem1_5_reg;
    year_t       year5_reg;
    hour_t       hour5_reg;
    minute_t     min5_reg;
    second_t     sec5_reg;
    // stage 6: 4-year cycle removal
    logic [4:0]  s6_c4;
    logic [15:0] s6_sub;
    logic [15:0] s6_rem;
    logic [10:0] rem2_6_reg;
    year_t       year6_reg;
    hour_t       hour6_reg;
    minute_t     min6_reg;
    second_t     sec6_reg;
    // stage 7: year within the 4-year cycle
    logic [1:0]  s7_c1;
    logic [10:0] s7_rem;
    logic [8:0]  rem3_7_reg;
    year_t       year7_reg;
    hour_t       hour7_reg;
    minute_t     min7_reg;
    second_t     sec7_reg;
    // stage 8: month and day
    logic [3:0]  s8_m;
    logic [8:0]  s8_day;
    year_t       year_reg, year_next;
    month_t      month_reg, month_next;
    day_t        day_reg;
    hour_t       hour_reg;
    minute_t     minute_reg;
    second_t     second_reg;

    // ---------------- handshake ----------------
    always_comb begin
        stage_en[NUM_STAGES-1] = !vld_reg[NUM_STAGES-1] || m_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            stage_en[k] = !vld_reg[k] || stage_en[k+1];
        end
    end

    always_comb begin
        vld_next = vld_reg;
        if (stage_en[0]) begin
            vld_next[0] = s_valid;
        end
        for (int k = 1; k < NUM_STAGES; k++) begin
            if (stage_en[k]) begin
                vld_next[k] = vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign s_ready = stage_en[0];
    assign m_valid = vld_reg[NUM_STAGES-1];

    // ---------------- datapath ----------------
    assign s0_prod = {26'b0, s_epoch_seconds[31:SOD_SHIFT]} * {25'b0, RECIP_675};

    assign s1_prod = {10'b0, q0_reg} * {16'b0, DIV_675};

    assign s2_diff = x1_reg - qm1_reg;

    always_comb begin
        if (s2_diff[10:0] >= {1'b0, DIV_675}) begin
            s2_rem = s2_diff[10:0] - {1'b0, DIV_675};
        end else begin
            s2_rem = s2_diff[10:0];
        end
    end

    assign s3_days = {2'b0, wd2_reg} + DAYS_REBASE;
    assign s3_c400 = (s3_days >= DAYS_400Y);
    assign s3_prod = {16'b0, sod2_reg[16:2]} * {15'b0, RECIP_15};

    always_comb begin
        s4_c100 = 2'd0;
        for (int i = 1; i < 4; i++) begin
            if (rem0_3_reg >= CENT_DAYS[i]) begin
                s4_c100 = 2'(i);
            end
        end
    end

    assign s4_rem  = rem0_3_reg - CENT_DAYS[s4_c100];
    assign s4_sec  = sod3_reg - ({mins3_reg, 6'b0} - {4'b0, mins3_reg, 2'b0});
    assign s4_prod = {16'b0, mins3_reg[10:2]} * {9'b0, RECIP_15};

    assign s5_prod = {16'b0, rem1_4_reg} * {16'b0, RECIP_1461};
    assign s5_min  = mins4_reg - ({hour4_reg, 6'b0} - {4'b0, hour4_reg, 2'b0});

    assign s6_c4  = (c4raw5_reg == C4_CLAMP) ? C4_CLAMP - 5'd1 : c4raw5_reg;
    assign s6_sub = {11'b0, s6_c4} * {5'b0, DAYS_4Y};
    assign s6_rem = rem1_5_reg - s6_sub;

    always_comb begin
        s7_c1 = 2'd0;
        for (int i = 1; i < 4; i++) begin
            if (rem2_6_reg >= YEAR_DAYS[i]) begin
                s7_c1 = 2'(i);
            end
        end
    end

    assign s7_rem = rem2_6_reg - YEAR_DAYS[s7_c1];

    always_comb begin
        s8_m = 4'd0;
        for (int i = 1; i < 12; i++) begin
            if (rem3_7_reg >= MONTH_START[i]) begin
                s8_m = s8_m + 4'd1;
            end
        end
    end

    assign s8_day = rem3_7_reg - MONTH_START[s8_m] + 9'd1;

    // january and february belong to the following year
    always_comb begin
        if (s8_m >= FIRST_NEXT_YEAR_MONTH) begin
            month_next = s8_m - 4'd9;
            year_next  = year7_reg + 12'd1;
        end else begin
            month_next = s8_m + 4'd3;
            year_next  = year7_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            q0_reg  <= s0_prod[50:RECIP_675_SHIFT];
            x0_reg  <= s_epoch_seconds[31:SOD_SHIFT];
            lo0_reg <= s_epoch_seconds[SOD_SHIFT-1:0];
        end
        if (stage_en[1]) begin
            q1_reg  <= q0_reg;
            x1_reg  <= x0_reg;
            qm1_reg <= s1_prod[24:0];
            lo1_reg <= lo0_reg;
        end
        if (stage_en[2]) begin
            if (s2_diff[10:0] >= {1'b0, DIV_675}) begin
                wd2_reg <= q1_reg + 16'd1;
            end else begin
                wd2_reg <= q1_reg;
            end
            sod2_reg <= {s2_rem[9:0], lo1_reg};
        end
        if (stage_en[3]) begin
            rem0_3_reg <= s3_c400 ? s3_days - DAYS_400Y : s3_days;
            c400_3_reg <= s3_c400;
            sod3_reg   <= sod2_reg;
            mins3_reg  <= s3_prod[29:RECIP_15_SHIFT];
        end
        if (stage_en[4]) begin
            rem1_4_reg <= s4_rem[15:0];
            year4_reg  <= BASE_YEAR + (c400_3_reg ? YEARS_400 : 12'd0) + CENT_YEARS[s4_c100];
            mins4_reg  <= mins3_reg;
            hour4_reg  <= s4_prod[23:RECIP_15_SHIFT];
            sec4_reg   <= s4_sec[5:0];
        end
        if (stage_en[5]) begin
            c4raw5_reg <= s5_prod[30:RECIP_1461_SHIFT];
            rem1_5_reg <= rem1_4_reg;
            year5_reg  <= year4_reg;
            hour5_reg  <= hour4_reg;
            min5_reg   <= s5_min[5:0];
            sec5_reg   <= sec4_reg;
        end
        if (stage_en[6]) begin
            rem2_6_reg <= s6_rem[10:0];
            year6_reg  <= year5_reg + {5'b0, s6_c4, 2'b0};
            hour6_reg  <= hour5_reg;
            min6_reg   <= min5_reg;
            sec6_reg   <= sec5_reg;
        end
        if (stage_en[7]) begin
            rem3_7_reg <= s7_rem[8:0];
            year7_reg  <= year6_reg + {10'b0, s7_c1};
            hour7_reg  <= hour6_reg;
            min7_reg   <= min6_reg;
            sec7_reg   <= sec6_reg;
        end
        if (stage_en[8]) begin
            year_reg   <= year_next;
            month_reg  <= month_next;
            day_reg    <= s8_day[4:0];
            hour_reg   <= hour7_reg;
            minute_reg <= min7_reg;
            second_reg <= sec7_reg;
        end
    end

    assign m_year   = year_reg;
    assign m_month  = month_reg;
    assign m_day    = day_reg;
    assign m_hour   = hour_reg;
    assign m_minute = minute_reg;
    assign m_second = second_reg;

`ifndef SYNTH
    // an empty output stage means the whole pipeline can move
    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled while output stage empty");

    a_date_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_month >= 4'd1 && m_month <= 4'd12 && m_day >= 5'd1
                     && m_year >= 12'd2000 && m_year <= 12'd2136))
        else $error("date field out of range");

    a_time_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_hour <= 5'd23 && m_minute <= 6'd59 && m_second <= 6'd59))
        else $error("time field out of range");

    a_empty_after_reset: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid)
        else $error("result valid right after reset");
`endif

endmodule

// ===== test/tb_epoch_seconds_to_calendar_date_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_epoch_seconds_to_calendar_date_unit
// Self-checking bench for the seconds-to-calendar-date pipeline. A local
// calendar predictor works out the date and time of every accepted request.
// The expected dates are queued, and each result is compared field by field
// in order. Stimulus covers day, month, year and century edges, leap days,
// the input extremes and random counts. Both sides idle at random. One
// long output stall makes the pipeline fill up and push back.
// ----------------------------------------------------------------------------
module tb_epoch_seconds_to_calendar_date_unit;

    localparam int unsigned SECONDS_PER_DAY = 86400;
    localparam int unsigned DAYS_PER_ERA    = 146097;
    localparam int unsigned DAYS_PER_CENT   = 36524;
    localparam int unsigned DAYS_PER_QUAD   = 1461;
    localparam int unsigned DAYS_PER_YEAR   = 365;
    localparam int unsigned JAN_FEB_LEN     = 60;
    localparam int unsigned ERA_BASE_YEAR   = 1600;
    localparam int unsigned LAST_FULL_DAY   = 49709;
    localparam int unsigned HOLD_OFF_CYCLES = 120;
    localparam int unsigned DRAIN_CYCLES    = 30;
    localparam int unsigned CYCLE_LIMIT     = 300000;
    localparam int unsigned MAX_PRINTED     = 20;
    localparam int unsigned MARCH_MONTH_LEN [12] = '{
        31, 30, 31, 30, 31, 31, 30, 31, 30, 31, 31, 29
    };

    typedef struct packed {
        es2cd_pkg::year_t   year;
        es2cd_pkg::month_t  month;
        es2cd_pkg::day_t    day;
        es2cd_pkg::hour_t   hour;
        es2cd_pkg::minute_t minute;
        es2cd_pkg::second_t second;
    } calendar_t;

    typedef struct packed {
        es2cd_pkg::epoch_t secs;
        calendar_t         date;
    } pending_date_t;

    logic                aclk;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    es2cd_pkg::epoch_t   s_epoch_seconds = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    es2cd_pkg::year_t    m_year;
    es2cd_pkg::month_t   m_month;
    es2cd_pkg::day_t     m_day;
    es2cd_pkg::hour_t    m_hour;
    es2cd_pkg::minute_t  m_minute;
    es2cd_pkg::second_t  m_second;

    pending_date_t pending_dates [$];
    int unsigned   mismatch_count = 0;
    int unsigned   cycle_count    = 0;
    int unsigned   holds_asked    = 0;
    int unsigned   holds_done     = 0;
    bit            calm           = 1'b0;

    epoch_seconds_to_calendar_date_unit dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_epoch_seconds (s_epoch_seconds),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_year          (m_year),
        .m_month         (m_month),
        .m_day           (m_day),
        .m_hour          (m_hour),
        .m_minute        (m_minute),
        .m_second        (m_second)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // date and time of a count of seconds since 2000-01-01
    function automatic calendar_t calendar_of(es2cd_pkg::epoch_t secs);
        int unsigned days, sod, since_era, era, rem, cent, quad, yr_in_quad, yr;
        int unsigned mar_month, month0;
        calendar_t   date;
        days       = secs / SECONDS_PER_DAY;
        sod        = secs % SECONDS_PER_DAY;
        since_era  = days + DAYS_PER_ERA - JAN_FEB_LEN;
        era        = since_era / DAYS_PER_ERA;
        rem        = since_era % DAYS_PER_ERA;
        cent       = rem / DAYS_PER_CENT;
        if (cent == 4) begin
            cent = 3;
        end
        rem        = rem - cent * DAYS_PER_CENT;
        quad       = rem / DAYS_PER_QUAD;
        if (quad == 25) begin
            quad = 24;
        end
        rem        = rem - quad * DAYS_PER_QUAD;
        yr_in_quad = rem / DAYS_PER_YEAR;
        if (yr_in_quad == 4) begin
            yr_in_quad = 3;
        end
        rem        = rem - yr_in_quad * DAYS_PER_YEAR;
        yr = ERA_BASE_YEAR + 400 * era + 100 * cent + 4 * quad + yr_in_quad;
        mar_month = 0;
        while (mar_month < 11 && MARCH_MONTH_LEN[mar_month] <= rem) begin
            rem       = rem - MARCH_MONTH_LEN[mar_month];
            mar_month = mar_month + 1;
        end
        month0 = mar_month + 2;
        if (month0 >= 12) begin
            month0 = month0 - 12;
            yr     = yr + 1;
        end
        date.year   = 12'(yr);
        date.month  = 4'(month0 + 1);
        date.day    = 5'(rem + 1);
        date.hour   = 5'(sod / 3600);
        date.minute = 6'((sod / 60) % 60);
        date.second = 6'(sod % 60);
        return date;
    endfunction

    task automatic report_mismatch(string msg);
        if (mismatch_count < MAX_PRINTED) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
        mismatch_count++;
    endtask

    task automatic check_field(string name, es2cd_pkg::epoch_t secs, int got, int want);
        if (got != want) begin
            report_mismatch($sformatf("%s for %0d seconds: got %0d, expected %0d",
                                      name, secs, got, want));
        end
    endtask

    // request capture and in-order result check
    always @(posedge aclk) begin
        pending_date_t exp_date;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                pending_dates.push_back('{s_epoch_seconds, calendar_of(s_epoch_seconds)});
            end
            if (m_valid && m_ready) begin
                if (pending_dates.size() == 0) begin
                    report_mismatch("result with no request outstanding");
                end else begin
                    exp_date = pending_dates.pop_front();
                    check_field("year", exp_date.secs, int'(m_year),
                                int'(exp_date.date.year));
                    check_field("month", exp_date.secs, int'(m_month),
                                int'(exp_date.date.month));
                    check_field("day", exp_date.secs, int'(m_day),
                                int'(exp_date.date.day));
                    check_field("hour", exp_date.secs, int'(m_hour),
                                int'(exp_date.date.hour));
                    check_field("minute", exp_date.secs, int'(m_minute),
                                int'(exp_date.date.minute));
                    check_field("second", exp_date.secs, int'(m_second),
                                int'(exp_date.date.second));
                end
            end
        end
    end

    // result port backpressure, with one long hold-off
    initial begin
        forever begin
            @(posedge aclk);
            if (holds_done != holds_asked) begin
                holds_done++;
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            end
            m_ready <= calm || ($urandom_range(99) >= 20);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_epoch_seconds_to_calendar_date_unit failed");
            $finish;
        end
    end

    task automatic send_request(es2cd_pkg::epoch_t secs);
        s_valid         <= 1'b1;
        s_epoch_seconds <= secs;
        do @(posedge aclk); while (!s_ready);
        if (!calm && $urandom_range(99) < 10) begin
            s_valid         <= 1'b0;
            s_epoch_seconds <= $urandom();
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
    endtask

    function automatic es2cd_pkg::epoch_t seconds_at(int unsigned day_idx,
                                                     int unsigned sod);
        return es2cd_pkg::epoch_t'(day_idx * SECONDS_PER_DAY + sod);
    endfunction

    task automatic test_calendar_edges();
        es2cd_pkg::epoch_t edges [$];
        edges = '{
            32'd0, 32'd59, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
            seconds_at(30, 86399), seconds_at(31, 0),
            seconds_at(59, 0), seconds_at(59, 86399), seconds_at(60, 0),
            seconds_at(365, 86399), seconds_at(366, 0),
            seconds_at(1520, 43210), seconds_at(1521, 0),
            seconds_at(36583, 86399), seconds_at(36584, 0),
            32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'hAAAA_AAAA, 32'h5555_5555,
            32'h8000_0000, 32'h7FFF_FFFF
        };
        foreach (edges[i]) begin
            send_request(edges[i]);
        end
    endtask

    task automatic test_random_counts(int unsigned count);
        repeat (count) begin
            send_request($urandom());
        end
    endtask

    // 00:00:00, 23:59:59 or random times, to hit day, month and year rollovers
    task automatic test_random_midnights(int unsigned count);
        int unsigned day_idx, sod;
        repeat (count) begin
            day_idx = $urandom_range(LAST_FULL_DAY, 0);
            case ($urandom_range(2))
                0: sod = 0;
                1: sod = SECONDS_PER_DAY - 1;
                default: sod = $urandom_range(SECONDS_PER_DAY - 1);
            endcase
            send_request(seconds_at(day_idx, sod));
        end
    endtask

    task automatic test_back_to_back(int unsigned count);
        calm = 1'b1;
        test_random_counts(count);
        calm = 1'b0;
    endtask

    task automatic test_output_hold_off(int unsigned count);
        calm = 1'b1;
        holds_asked++;
        test_random_midnights(count);
        calm = 1'b0;
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        test_calendar_edges();
        test_random_counts(350);
        test_back_to_back(80);
        test_random_midnights(300);
        test_output_hold_off(50);
        test_random_counts(40);
        s_valid <= 1'b0;
        while (pending_dates.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("tb_epoch_seconds_to_calendar_date_unit passed");
        end else begin
            $display("tb_epoch_seconds_to_calendar_date_unit failed");
        end
        $finish;
    end

endmodule

// ===== epoch_seconds_to_calendar_date_unit.f =====
hw/rtl/es2cd_pkg.sv
hw/rtl/epoch_seconds_to_calendar_date_unit.sv
test/tb_epoch_seconds_to_calendar_date_unit.sv
